/* rtl/gcl_pkg.sv */
// Shared types, opcodes and result codes for the command list parser.
package gcl_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0] OpPad  = 8'h00;
    localparam logic [7:0] OpCp   = 8'h08;
    localparam logic [7:0] OpXf   = 8'h10;
    localparam logic [7:0] OpBp   = 8'h61;
    localparam logic [7:0] OpDraw = 8'h80;

    localparam int OutDataWidth = 72;

    typedef enum logic [2:0] {
        KIND_CP_WRITE  = 3'd0,
        KIND_BP_WRITE  = 3'd1,
        KIND_XF_WRITE  = 3'd2,
        KIND_DRAW_STOP = 3'd3,
        KIND_UNKNOWN   = 3'd4,
        KIND_TRUNCATED = 3'd5,
        KIND_END_ONLY  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        OPC_PAD,
        OPC_CP,
        OPC_BP,
        OPC_XF,
        OPC_DRAW,
        OPC_OTHER
    } opclass_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CP_REG  = 4'd1,
        PH_CP_VAL  = 4'd2,
        PH_BP_VAL  = 4'd3,
        PH_XF_CNT  = 4'd4,
        PH_XF_ADDR = 4'd5,
        PH_XF_DATA = 4'd6,
        PH_DRAW    = 4'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] list_byte;
        logic       final_byte;
        opclass_t   opclass;
    } entry_t;

    function automatic opclass_t classify(input logic [7:0] b);
        opclass_t c;
        if (b == OpPad) begin
            c = OPC_PAD;
        end else if (b >= OpDraw) begin
            c = OPC_DRAW;
        end else if (b == OpCp) begin
            c = OPC_CP;
        end else if (b == OpBp) begin
            c = OPC_BP;
        end else if (b == OpXf) begin
            c = OPC_XF;
        end else begin
            c = OPC_OTHER;
        end
        return c;
    endfunction

endpackage

/* rtl/gcl_front.sv */
// Front end: accepts list bytes, classifies them as opcodes and queues them.
module gcl_front #(
    parameter int QUEUE_DEPTH = gcl_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] list_byte
    input  logic            s_tlast,
    output logic            q_valid,
    output gcl_pkg::entry_t q_entry,
    input  logic            q_pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    gcl_pkg::entry_t mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push;
    gcl_pkg::entry_t wr_entry;

    assign s_tready = (count_reg != FullCnt);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_entry.list_byte  = s_tdata;
        wr_entry.final_byte = s_tlast;
        wr_entry.opclass    = gcl_pkg::classify(s_tdata);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !q_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

/* rtl/gcl_back.sv */
// Back end: command state machine and registered result output.
module gcl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  gcl_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [gcl_pkg::OutDataWidth-1:0] m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    gcl_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  regbyte_reg, regbyte_next;
    logic [31:0] word_reg, word_next;
    logic [15:0] xf_addr_reg, xf_addr_next;
    logic [16:0] xf_left_reg, xf_left_next;
    logic        halted_reg, halted_next;

    logic        m_valid_reg, m_valid_next;
    logic [gcl_pkg::OutDataWidth-1:0] m_data_reg;
    logic [2:0]  m_user_reg;
    logic        m_last_reg;

    logic [7:0]  b;
    logic [31:0] word_sh;
    logic [2:0]  cnt_inc;
    logic [16:0] left_dec;
    logic        emit;
    gcl_pkg::kind_t kind;
    logic [15:0] r_addr;
    logic [31:0] r_value;
    logic [15:0] r_vcount;
    logic [7:0]  r_cmd;
    logic        r_last;

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign b        = q_entry.list_byte;
    assign word_sh  = {word_reg[23:0], b};
    assign cnt_inc  = cnt_reg + 3'd1;
    assign left_dec = xf_left_reg - 17'd1;

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        opcode_next  = opcode_reg;
        regbyte_next = regbyte_reg;
        word_next    = word_reg;
        xf_addr_next = xf_addr_reg;
        xf_left_next = xf_left_reg;
        halted_next  = halted_reg;
        emit     = 1'b0;
        kind     = gcl_pkg::KIND_CP_WRITE;
        r_addr   = '0;
        r_value  = '0;
        r_vcount = '0;
        r_cmd    = '0;
        r_last   = 1'b0;

        if (!halted_reg) begin
            case (phase_reg)
                gcl_pkg::PH_IDLE: begin
                    opcode_next = b;
                    cnt_next    = '0;
                    word_next   = '0;
                    case (q_entry.opclass)
                        gcl_pkg::OPC_PAD:  phase_next = gcl_pkg::PH_IDLE;
                        gcl_pkg::OPC_DRAW: phase_next = gcl_pkg::PH_DRAW;
                        gcl_pkg::OPC_CP:   phase_next = gcl_pkg::PH_CP_REG;
                        gcl_pkg::OPC_BP:   phase_next = gcl_pkg::PH_BP_VAL;
                        gcl_pkg::OPC_XF:   phase_next = gcl_pkg::PH_XF_CNT;
                        default: begin
                            emit        = 1'b1;
                            kind        = gcl_pkg::KIND_UNKNOWN;
                            r_cmd       = b;
                            halted_next = 1'b1;
                        end
                    endcase
                end
                gcl_pkg::PH_CP_REG: begin
                    regbyte_next = b;
                    phase_next   = gcl_pkg::PH_CP_VAL;
                    cnt_next     = '0;
                    word_next    = '0;
                end
                gcl_pkg::PH_CP_VAL: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd4) begin
                        emit       = 1'b1;
                        kind       = gcl_pkg::KIND_CP_WRITE;
                        r_addr     = {8'd0, regbyte_reg};
                        r_value    = word_sh;
                        phase_next = gcl_pkg::PH_IDLE;
                        cnt_next   = '0;
                        word_next  = '0;
                    end
                end
                gcl_pkg::PH_BP_VAL: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd4) begin
                        emit       = 1'b1;
                        kind       = gcl_pkg::KIND_BP_WRITE;
                        r_addr     = {8'd0, word_sh[31:24]};
                        r_value    = {8'd0, word_sh[23:0]};
                        phase_next = gcl_pkg::PH_IDLE;
                        cnt_next   = '0;
                        word_next  = '0;
                    end
                end
                gcl_pkg::PH_XF_CNT: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd2) begin
                        xf_left_next = {1'b0, word_sh[15:0]} + 17'd1;
                        phase_next   = gcl_pkg::PH_XF_ADDR;
                        cnt_next     = '0;
                        word_next    = '0;
                    end
                end
                gcl_pkg::PH_XF_ADDR: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd2) begin
                        xf_addr_next = word_sh[15:0];
                        phase_next   = gcl_pkg::PH_XF_DATA;
                        cnt_next     = '0;
                        word_next    = '0;
                    end
                end
                gcl_pkg::PH_XF_DATA: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd4) begin
                        emit         = 1'b1;
                        kind         = gcl_pkg::KIND_XF_WRITE;
                        r_addr       = xf_addr_reg;
                        r_value      = word_sh;
                        xf_addr_next = xf_addr_reg + 16'd1;
                        xf_left_next = left_dec;
                        phase_next   = (left_dec == '0) ? gcl_pkg::PH_IDLE
                                                        : gcl_pkg::PH_XF_DATA;
                        cnt_next     = '0;
                        word_next    = '0;
                    end
                end
                gcl_pkg::PH_DRAW: begin
                    word_next = word_sh;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == 3'd2) begin
                        emit        = 1'b1;
                        kind        = gcl_pkg::KIND_DRAW_STOP;
                        r_vcount    = word_sh[15:0];
                        r_cmd       = opcode_reg;
                        halted_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = gcl_pkg::PH_IDLE;
                    cnt_next   = '0;
                    word_next  = '0;
                end
            endcase
        end

        // final byte: report truncation or end, then start a fresh list
        if (q_entry.final_byte) begin
            if (!halted_next && phase_next != gcl_pkg::PH_IDLE) begin
                kind     = gcl_pkg::KIND_TRUNCATED;
                r_addr   = '0;
                r_value  = '0;
                r_vcount = '0;
                r_cmd    = '0;
            end else if (!emit) begin
                kind = gcl_pkg::KIND_END_ONLY;
            end
            r_last       = 1'b1;
            emit         = 1'b1;
            phase_next   = gcl_pkg::PH_IDLE;
            cnt_next     = '0;
            opcode_next  = '0;
            regbyte_next = '0;
            word_next    = '0;
            xf_addr_next = '0;
            xf_left_next = '0;
            halted_next  = 1'b0;
        end

        m_valid_next = q_pop ? emit : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= gcl_pkg::PH_IDLE;
            cnt_reg     <= '0;
            opcode_reg  <= '0;
            regbyte_reg <= '0;
            word_reg    <= '0;
            xf_addr_reg <= '0;
            xf_left_reg <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                phase_reg   <= phase_next;
                cnt_reg     <= cnt_next;
                opcode_reg  <= opcode_next;
                regbyte_reg <= regbyte_next;
                word_reg    <= word_next;
                xf_addr_reg <= xf_addr_next;
                xf_left_reg <= xf_left_next;
                halted_reg  <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            m_data_reg <= {r_cmd, r_vcount, r_value, r_addr};
            m_user_reg <= kind;
            m_last_reg <= r_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/gpu_command_list_parser.sv */
// Command list parser top level: byte queue front end and command back end.
// An accepted byte is stored in the queue, then its request is registered at
// the output. Throughput: one byte per cycle unless m_tready stalls the output,
// set by the single-byte back end state machine.
// Reset: aresetn, synchronous active low, empties the queue and returns the
// parser to waiting for an opcode.
module gpu_command_list_parser #(
    parameter int QUEUE_DEPTH = gcl_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] list_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] reg_address, [47:16] reg_value, [63:48] vertex_count,
    // [71:64] command_byte
    output logic [gcl_pkg::OutDataWidth-1:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // list_end
);

    logic            q_valid;
    logic            q_pop;
    gcl_pkg::entry_t q_entry;

    gcl_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    gcl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
